FILE: hw/rtl/ndps_pkg.sv
// Shared types, codes and the quarter-wave sine table for the dome point search.
package ndps_pkg;

	localparam int CFG_W      = 11;
	localparam int SLOT_W     = 10;
	localparam int FIELD_W    = 16;
	localparam int POL_W      = 7;
	localparam int AZ_W       = 9;
	localparam int TABLE_FRAC = 14;
	localparam int MAG_W      = 15;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [9:0] DEG_90  = 10'd90;
	localparam logic [9:0] DEG_180 = 10'd180;
	localparam logic [9:0] DEG_270 = 10'd270;
	localparam logic [9:0] DEG_360 = 10'd360;

	typedef struct packed {
		logic                      req_type;
		logic [SLOT_W-1:0]         point_index;
		logic signed [FIELD_W-1:0] point_x;
		logic signed [FIELD_W-1:0] point_y;
		logic signed [FIELD_W-1:0] point_z;
		logic [POL_W-1:0]          polar_deg;
		logic [AZ_W-1:0]           azimuth_deg;
	} req_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] nearest_index;
		logic              found;
	} res_word_t;

	typedef logic [CFG_W-1:0] cfg_word_t;

	// sine as sign and Q14 magnitude
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sin_t;

	localparam logic [MAG_W-1:0] QUARTER_SINE [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997, 15'd2280,
		15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240, 15'd4516,
		15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402, 15'd6664,
		15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682,
		15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
		15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
		15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330,
		15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191,
		15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826,
		15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225,
		15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// input below 720
	function automatic logic [9:0] wrap360(logic [9:0] d);
		return (d >= DEG_360) ? d - DEG_360 : d;
	endfunction

	// input below 360
	function automatic sin_t sine_of(logic [9:0] d);
		sin_t s;
		if (d <= DEG_90) begin
			s.neg = 1'b0;
			s.mag = QUARTER_SINE[7'(d)];
		end else if (d <= DEG_180) begin
			s.neg = 1'b0;
			s.mag = QUARTER_SINE[7'(DEG_180 - d)];
		end else if (d <= DEG_270) begin
			s.neg = 1'b1;
			s.mag = QUARTER_SINE[7'(d - DEG_180)];
		end else begin
			s.neg = 1'b1;
			s.mag = QUARTER_SINE[7'(DEG_360 - d)];
		end
		return s;
	endfunction

	function automatic sin_t cosine_of(logic [9:0] d);
		return sine_of(wrap360(wrap360(d) + DEG_90));
	endfunction

endpackage

FILE: hw/rtl/ndps_chan_if.sv
// Valid/ready channel carrying one word of a given type.
interface ndps_chan_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ndps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ndps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/nearest_dome_point_search.sv
// Brute-force nearest dome point search over a RAM of unit-sphere points.
//
// Channels: req (sink) carries load and query words, res (source) carries one
// result word per query, cfg (sink, always ready) writes points_in_use.
// A load word writes one slot; a slot at or beyond
// MAX_POINTS is dropped. Loads give no result.
// A query forms its direction vector from the sine table and one shared
// rounding multiplier (MULX, MULY), then streams the n points in use through
// the RAM read port and a distance unit, one point a cycle.
// A query is busy from acceptance until its result word is registered: MULX,
// MULY, SCAN (RAM read, squares register, sum and compare), then DONE, which
// waits while the output word is still pending. req is not ready meanwhile.
// The result sits in an output register; a stalled receiver does not hold up
// loads, but a second query waits at its end until the first word is taken.
// Reset clears control state and points_in_use; table contents are undefined
// until loaded, and scanning an unloaded slot gives an undefined index.
// The index returned is the first of the nearest points.
module nearest_dome_point_search #(
	parameter int MAX_POINTS      = 1024,
	parameter int COORD_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	ndps_chan_if.sink   req,
	ndps_chan_if.source res,
	ndps_chan_if.sink   cfg
);
	import ndps_pkg::*;

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int QW    = COORD_FRAC_BITS + 2;
	localparam int DW    = (QW > FIELD_W) ? QW + 1 : FIELD_W + 1;
	localparam int SQW   = 2 * DW;
	localparam int SW    = SQW + 2;
	localparam int PW    = 2 * QW;
	localparam int SH_UP = (COORD_FRAC_BITS >= TABLE_FRAC) ? COORD_FRAC_BITS - TABLE_FRAC : 0;
	localparam int SH_DN = (COORD_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - COORD_FRAC_BITS : 1;
	localparam int PT_W  = 3 * FIELD_W;

	typedef enum logic [2:0] {ST_IDLE, ST_MULX, ST_MULY, ST_SCAN, ST_DONE} state_t;

	function automatic logic signed [QW-1:0] to_coord(sin_t s);
		logic [FIELD_W:0] dn;
		logic [QW-1:0]    m;
		dn = (FIELD_W + 1)'(s.mag) + (FIELD_W + 1)'(1 << (SH_DN - 1));
		if (COORD_FRAC_BITS >= TABLE_FRAC) begin
			m = QW'(s.mag) << SH_UP;
		end else begin
			m = QW'(dn >> SH_DN);
		end
		return s.neg ? -$signed(m) : $signed(m);
	endfunction

	// sign-magnitude product, halves rounded away from zero
	function automatic logic signed [QW-1:0] qmul(logic signed [QW-1:0] a,
	                                              logic signed [QW-1:0] b);
		logic          neg;
		logic [QW-1:0] ua;
		logic [QW-1:0] ub;
		logic [PW-1:0] p;
		logic [QW-1:0] m;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? QW'(-a) : QW'(a);
		ub  = (b < 0) ? QW'(-b) : QW'(b);
		p   = PW'(ua) * PW'(ub) + PW'(1 << (COORD_FRAC_BITS - 1));
		m   = QW'(p >> COORD_FRAC_BITS);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        issue_q;
	logic                 v_s1, v_s2;
	logic                 first_q;
	logic [SW-1:0]        best_q;
	logic [AW-1:0]        best_idx_q;
	logic                 res_valid_q;
	res_word_t            res_q;

	logic signed [QW-1:0] caz_q, saz_q, sp_q, qz_q, qx_q, qy_q;
	logic [AW-1:0]        idx_s1, idx_s2;
	logic [SQW-1:0]       sqx_s2, sqy_s2, sqz_s2;

	req_word_t            rq;
	logic                 req_acc;
	logic                 is_query;
	logic                 slot_ok;
	logic [CW-1:0]        n_sat;
	logic [9:0]           pol_deg, az_deg;
	logic signed [QW-1:0] mul_a, mul_p;
	logic                 rd_en;
	logic                 scan_done;
	logic [PT_W-1:0]      rdata;
	logic signed [DW-1:0] dx_c, dy_c, dz_c;
	logic signed [SQW-1:0] px_c, py_c, pz_c;
	logic [SW-1:0]        sum_c;

	assign rq       = req.data;
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc  = req.valid && req.ready;
	assign is_query = (rq.req_type == REQ_QUERY);
	assign slot_ok  = 32'(rq.point_index) < MAX_POINTS;
	assign n_sat    = (32'(cfg_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cfg_q);

	assign pol_deg  = 10'(rq.polar_deg);
	assign az_deg   = wrap360(10'(rq.azimuth_deg));

	assign mul_a    = (state_q == ST_MULX) ? caz_q : saz_q;
	assign mul_p    = qmul(mul_a, sp_q);

	assign rd_en     = (state_q == ST_SCAN) && (issue_q != n_q);
	assign scan_done = (state_q == ST_SCAN) && (issue_q == n_q) && !v_s1 && !v_s2;

	assign cfg.ready = 1'b1;

	ndps_ram #(
		.WIDTH (PT_W),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (req_acc && (rq.req_type == REQ_LOAD) && slot_ok),
		.waddr (AW'(rq.point_index)),
		.wdata ({rq.point_x, rq.point_y, rq.point_z}),
		.re    (rd_en),
		.raddr (issue_q[AW-1:0]),
		.rdata (rdata)
	);

	// distance unit: differences and squares, then sum and compare
	assign dx_c  = DW'(qx_q) - DW'($signed(rdata[3*FIELD_W-1:2*FIELD_W]));
	assign dy_c  = DW'(qy_q) - DW'($signed(rdata[2*FIELD_W-1:FIELD_W]));
	assign dz_c  = DW'(qz_q) - DW'($signed(rdata[FIELD_W-1:0]));
	assign px_c  = dx_c * dx_c;
	assign py_c  = dy_c * dy_c;
	assign pz_c  = dz_c * dz_c;
	assign sum_c = SW'(sqx_s2) + SW'(sqy_s2) + SW'(sqz_s2);

	always_ff @(posedge clk) begin
		if (req_acc && is_query) begin
			sp_q  <= to_coord(sine_of(pol_deg));
			qz_q  <= to_coord(cosine_of(pol_deg));
			caz_q <= to_coord(cosine_of(az_deg));
			saz_q <= to_coord(sine_of(az_deg));
		end
		if (state_q == ST_MULX) begin
			qx_q <= mul_p;
		end
		if (state_q == ST_MULY) begin
			qy_q <= mul_p;
		end
		idx_s1 <= issue_q[AW-1:0];
		idx_s2 <= idx_s1;
		sqx_s2 <= SQW'($unsigned(px_c));
		sqy_s2 <= SQW'($unsigned(py_c));
		sqz_s2 <= SQW'($unsigned(pz_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= '0;
			n_q         <= '0;
			issue_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			first_q     <= 1'b1;
			best_q      <= '1;
			best_idx_q  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			if (cfg.valid && cfg.ready) begin
				cfg_q <= CFG_W'(cfg.data);
			end
			// the done state loads the next word itself
			if (res.valid && res.ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			if (v_s2 && (first_q || (sum_c < best_q))) begin
				best_q     <= sum_c;
				best_idx_q <= idx_s2;
				first_q    <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && is_query) begin
						n_q        <= n_sat;
						issue_q    <= '0;
						first_q    <= 1'b1;
						best_q     <= '1;
						best_idx_q <= '0;
						state_q    <= ST_MULX;
					end
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_q.nearest_index <= SLOT_W'(best_idx_q);
						res_q.found         <= (n_q != '0);
						res_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_SCAN))
		else $error("distance pipeline busy outside scan");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= n_q)
		else $error("scan address past points in use");

	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> (!res.data.found || (32'(best_idx_q) < 32'(n_q))))
		else $error("result index outside scanned range");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && res.valid && !res.ready) |=> $stable(res.data))
		else $error("pending result word overwritten");
endmodule
